// File: rtl/rit_pkg.sv
// Shared types and constants for the readiness interest table.
package rit_pkg;

    localparam int FD_W   = 4;
    localparam int INT_W  = 2;
    localparam int DATA_W = 64;
    localparam int MASK_W = 16;
    localparam int MAXEV_W = 5;

    // Descriptors at or above this number never count as open.
    localparam logic [FD_W:0] FD_COUNT = (FD_W + 1)'(16);

    // Most events one poll reports.
    localparam logic [MAXEV_W-1:0] RESULT_CAP = MAXEV_W'(16);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_MOD  = 2'd2,
        OP_POLL = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_OPEN  = 3'd1,
        ST_DUP       = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // One stored entry: descriptor, interest mask and user data.
    typedef struct packed {
        logic [FD_W-1:0]   fd;
        logic [INT_W-1:0]  interest;
        logic [DATA_W-1:0] data;
    } t_slot_word;

    typedef struct packed {
        logic reject;   // answer "not open" at once
        logic load;     // latch the request and start a table walk
        logic scan;     // walk in progress
        logic finish;   // close the request and emit its final result
    } t_ctl_cmd;

    typedef struct packed {
        logic reject;     // request on the inputs is refused outright
        logic scan_done;  // every slot read and processed
    } t_ctl_sts;

endpackage

// File: rtl/rit_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rit_ctrl.sv
// Sequencer for the readiness interest table: idle, table walk, finish.
module rit_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rit_pkg::t_ctl_sts i_sts,
    output rit_pkg::t_ctl_cmd o_cmd
);

    rit_pkg::t_state r_state;
    rit_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rit_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            rit_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_sts.reject) begin
                        o_cmd.reject = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = rit_pkg::S_SCAN;
                    end
                end
            end
            rit_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = rit_pkg::S_FINISH;
                end
            end
            rit_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = rit_pkg::S_IDLE;
            end
            default: begin
                n_state = rit_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rit_dpath.sv
// Datapath: request registers, slot store, valid bits, walk pipeline and result register.
module rit_dpath #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rit_pkg::t_ctl_cmd                i_cmd,
    output rit_pkg::t_ctl_sts                o_sts,
    input  logic [1:0]                       i_operation,
    input  logic [rit_pkg::FD_W-1:0]         i_fd,
    input  logic [rit_pkg::INT_W-1:0]        i_interest,
    input  logic [rit_pkg::DATA_W-1:0]       i_user_data,
    input  logic [rit_pkg::MAXEV_W-1:0]      i_max_events,
    input  logic [rit_pkg::MASK_W-1:0]       i_open_mask,
    input  logic [rit_pkg::MASK_W-1:0]       i_read_ready_mask,
    input  logic [rit_pkg::MASK_W-1:0]       i_write_ready_mask,
    output logic                             o_result_strobe,
    output logic [2:0]                       o_status,
    output logic                             o_has_event,
    output logic [1:0]                       o_ready_mask,
    output logic [rit_pkg::DATA_W-1:0]       o_event_data,
    output logic                             o_last
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [AW:0] SLOTS = (AW + 1)'(TABLE_SLOTS);
    localparam int WORD_W = $bits(rit_pkg::t_slot_word);

    // Request
    rit_pkg::t_op                   r_op;
    logic [rit_pkg::FD_W-1:0]       r_fd;
    logic [rit_pkg::INT_W-1:0]      r_interest;
    logic [rit_pkg::DATA_W-1:0]     r_data;
    logic [rit_pkg::MAXEV_W-1:0]    r_maxev;
    logic [rit_pkg::MASK_W-1:0]     r_open;
    logic [rit_pkg::MASK_W-1:0]     r_rd;
    logic [rit_pkg::MASK_W-1:0]     r_wr;

    // Walk
    logic [AW:0]                    r_scan;
    logic                           r_q_vld;
    logic [AW-1:0]                  r_q_idx;
    logic [TABLE_SLOTS-1:0]         r_valid;
    logic                           r_hit;
    logic                           r_free_vld;
    logic [AW-1:0]                  r_free_idx;
    logic [rit_pkg::MAXEV_W-1:0]    r_cnt;
    logic                           r_pend_vld;
    logic [1:0]                     r_pend_ready;
    logic [rit_pkg::DATA_W-1:0]     r_pend_data;

    // Result
    logic                           r_o_strobe;
    rit_pkg::t_status               r_o_status;
    logic                           r_o_has_event;
    logic [1:0]                     r_o_ready;
    logic [rit_pkg::DATA_W-1:0]     r_o_data;
    logic                           r_o_last;

    logic                  in_open;
    logic                  issue;
    rit_pkg::t_slot_word   q_word;
    rit_pkg::t_slot_word   w_word;
    logic [WORD_W-1:0]     ram_rdata;
    logic                  q_live;
    logic                  q_match;
    logic                  q_fd_open;
    logic [1:0]            q_ready;
    logic                  take_event;
    logic                  mod_write;
    logic                  add_write;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;

    assign in_open = ({1'b0, i_fd} < rit_pkg::FD_COUNT) && i_open_mask[i_fd];
    assign o_sts.reject = (rit_pkg::t_op'(i_operation) != rit_pkg::OP_POLL) && !in_open;
    assign o_sts.scan_done = (r_scan >= SLOTS) && !r_q_vld;

    assign issue = i_cmd.scan && (r_scan < SLOTS);

    assign q_word    = rit_pkg::t_slot_word'(ram_rdata);
    assign q_live    = r_q_vld && r_valid[r_q_idx];
    assign q_match   = q_live && (q_word.fd == r_fd);
    assign q_fd_open = ({1'b0, q_word.fd} < rit_pkg::FD_COUNT) && r_open[q_word.fd];
    assign q_ready   = {q_word.interest[1] & r_wr[q_word.fd],
                        q_word.interest[0] & r_rd[q_word.fd]};
    assign take_event = (r_op == rit_pkg::OP_POLL) && q_live && q_fd_open &&
                        (q_ready != 2'b00) && (r_cnt < r_maxev);

    assign mod_write = (r_op == rit_pkg::OP_MOD) && q_match && !r_hit;
    assign add_write = i_cmd.finish && (r_op == rit_pkg::OP_ADD) && !r_hit && r_free_vld;
    assign ram_we    = mod_write || add_write;
    assign ram_waddr = add_write ? r_free_idx : r_q_idx;

    always_comb begin
        w_word.fd       = add_write ? r_fd : q_word.fd;
        w_word.interest = r_interest;
        w_word.data     = r_data;
    end

    rit_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (w_word),
        .i_re    (issue),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Request latch and walk bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= rit_pkg::t_op'(i_operation);
            r_fd       <= i_fd;
            r_interest <= i_interest;
            r_data     <= i_user_data;
            r_maxev    <= (i_max_events > rit_pkg::RESULT_CAP) ? rit_pkg::RESULT_CAP
                                                               : i_max_events;
            r_open     <= i_open_mask;
            r_rd       <= i_read_ready_mask;
            r_wr       <= i_write_ready_mask;
            r_scan     <= '0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (issue) begin
                r_scan <= r_scan + 1'b1;
            end
            if (q_match && (r_op == rit_pkg::OP_ADD || r_op == rit_pkg::OP_MOD)) begin
                r_hit <= 1'b1;
            end
            if ((r_op == rit_pkg::OP_ADD) && r_q_vld && !r_valid[r_q_idx] && !r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_q_idx;
            end
            if (take_event) begin
                r_cnt        <= r_cnt + 1'b1;
                r_pend_ready <= q_ready;
                r_pend_data  <= q_word.data;
            end
        end
        r_q_idx <= r_scan[AW-1:0];
    end

    // Control state: read pipeline, valid bits, pending event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld    <= 1'b0;
            r_valid    <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_q_vld <= issue;
            if (i_cmd.load) begin
                r_pend_vld <= 1'b0;
            end else if (take_event) begin
                r_pend_vld <= 1'b1;
            end
            if ((r_op == rit_pkg::OP_DEL) && q_match) begin
                r_valid[r_q_idx] <= 1'b0;
            end
            if (add_write) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // Result register: one transfer per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= i_cmd.reject || i_cmd.finish || (take_event && r_pend_vld);
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_status    <= rit_pkg::ST_OK;
        r_o_has_event <= 1'b0;
        r_o_ready     <= 2'b00;
        r_o_data      <= '0;
        r_o_last      <= 1'b1;
        if (i_cmd.reject) begin
            r_o_status <= rit_pkg::ST_NOT_OPEN;
        end else if (i_cmd.finish) begin
            unique case (r_op)
                rit_pkg::OP_ADD: begin
                    if (r_hit) begin
                        r_o_status <= rit_pkg::ST_DUP;
                    end else if (!r_free_vld) begin
                        r_o_status <= rit_pkg::ST_FULL;
                    end
                end
                rit_pkg::OP_DEL: begin
                    r_o_status <= rit_pkg::ST_OK;
                end
                rit_pkg::OP_MOD: begin
                    if (!r_hit) begin
                        r_o_status <= rit_pkg::ST_NOT_FOUND;
                    end
                end
                rit_pkg::OP_POLL: begin
                    if (r_pend_vld) begin
                        r_o_has_event <= 1'b1;
                        r_o_ready     <= r_pend_ready;
                        r_o_data      <= r_pend_data;
                    end
                end
                default: begin
                    r_o_status <= rit_pkg::ST_OK;
                end
            endcase
        end else if (take_event && r_pend_vld) begin
            r_o_has_event <= 1'b1;
            r_o_ready     <= r_pend_ready;
            r_o_data      <= r_pend_data;
            r_o_last      <= 1'b0;
        end
    end

    assign o_result_strobe = r_o_strobe;
    assign o_status        = r_o_status;
    assign o_has_event     = r_o_has_event;
    assign o_ready_mask    = r_o_ready;
    assign o_event_data    = r_o_data;
    assign o_last          = r_o_last;

endmodule

// File: rtl/readiness_interest_table_core.sv
// Top level of the readiness interest table: sequencer plus datapath.
//
// A table of TABLE_SLOTS watched descriptors. Pulse start while busy is low to
// transfer a request (add, delete, modify or poll). An add, delete or modify
// naming a closed descriptor is refused at once: its single result appears in the
// cycle after the transfer and busy never rises. Every other request walks the
// whole slot store, one slot per cycle through the store's single read port, and
// then closes in the finish state; busy stays high until then, so the next
// request cannot be transferred before the current one has closed. Results
// appear on o_result_strobe for exactly one cycle each and cannot be held off:
// sample them whenever the strobe is high. A poll emits its events as the walk
// finds them (each one delayed until the next is found, so that o_last can mark
// the final one) and its last event, or a single empty result, when it
// closes. Add, delete and modify each give one result with o_last set.
module readiness_interest_table_core #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_operation,
    input  logic [rit_pkg::FD_W-1:0]         i_fd,
    input  logic [rit_pkg::INT_W-1:0]        i_interest,
    input  logic [rit_pkg::DATA_W-1:0]       i_user_data,
    input  logic [rit_pkg::MAXEV_W-1:0]      i_max_events,
    input  logic [rit_pkg::MASK_W-1:0]       i_open_mask,
    input  logic [rit_pkg::MASK_W-1:0]       i_read_ready_mask,
    input  logic [rit_pkg::MASK_W-1:0]       i_write_ready_mask,
    output logic                             o_result_strobe,
    output logic [2:0]                       o_status,
    output logic                             o_has_event,
    output logic [1:0]                       o_ready_mask,
    output logic [rit_pkg::DATA_W-1:0]       o_event_data,
    output logic                             o_last
);

    rit_pkg::t_ctl_cmd cmd;
    rit_pkg::t_ctl_sts sts;

    // Sequence each request: idle, walk the slots, close.
    rit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold the request, the slot store and the result register.
    rit_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_operation        (i_operation),
        .i_fd               (i_fd),
        .i_interest         (i_interest),
        .i_user_data        (i_user_data),
        .i_max_events       (i_max_events),
        .i_open_mask        (i_open_mask),
        .i_read_ready_mask  (i_read_ready_mask),
        .i_write_ready_mask (i_write_ready_mask),
        .o_result_strobe    (o_result_strobe),
        .o_status           (o_status),
        .o_has_event        (o_has_event),
        .o_ready_mask       (o_ready_mask),
        .o_event_data       (o_event_data),
        .o_last             (o_last)
    );

endmodule

// File: dv/readiness_interest_table_core_tb.sv
// Self-checking testbench for the readiness interest table core.
//
// Requests go out from a queue through a start/busy driver on the falling edge.
// A monitor on the rising edge notes each transfer, runs it through a
// behavioural copy of the table to queue the responses it should cause, and
// checks every strobed result against the oldest queued response. The sender
// pauses at random between requests. Every few dozen requests it holds off
// until the table has answered everything outstanding.
module readiness_interest_table_core_tb;

    localparam int FD_W    = rit_pkg::FD_W;
    localparam int INT_W   = rit_pkg::INT_W;
    localparam int DATA_W  = rit_pkg::DATA_W;
    localparam int MAXEV_W = rit_pkg::MAXEV_W;
    localparam int MASK_W  = rit_pkg::MASK_W;

    localparam int CLK_PERIOD    = 8;
    localparam int N_SLOTS       = 16;
    localparam int N_RANDOM      = 425;
    // Longest quiet spell in a correct run is one walk plus a gap.
    localparam int STALL_LIMIT   = 2000;
    // Allow two full walks after the last response for stray strobes to show.
    localparam int SETTLE_CYCLES = 2 * (N_SLOTS + 4);

    // One request as the sender presents it, plus its pacing.
    typedef struct {
        rit_pkg::t_op       op;
        logic [FD_W-1:0]    fd;
        logic [INT_W-1:0]   interest;
        logic [DATA_W-1:0]  user_data;
        logic [MAXEV_W-1:0] max_events;
        logic [MASK_W-1:0]  open_mask;
        logic [MASK_W-1:0]  rd_mask;
        logic [MASK_W-1:0]  wr_mask;
        int                 gap;    // idle cycles before this request goes out
        bit                 drain;  // hold until every response is in
    } t_request;

    // One response as the table reports it.
    typedef struct {
        rit_pkg::t_status   status;
        logic               has_event;
        logic [1:0]         ready_mask;
        logic [DATA_W-1:0]  event_data;
        logic               last;
    } t_response;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               start              = 1'b0;
    logic [1:0]         i_operation        = '0;
    logic [FD_W-1:0]    i_fd               = '0;
    logic [INT_W-1:0]   i_interest         = '0;
    logic [DATA_W-1:0]  i_user_data        = '0;
    logic [MAXEV_W-1:0] i_max_events       = '0;
    logic [MASK_W-1:0]  i_open_mask        = '0;
    logic [MASK_W-1:0]  i_read_ready_mask  = '0;
    logic [MASK_W-1:0]  i_write_ready_mask = '0;
    logic               busy;
    logic               o_result_strobe;
    logic [2:0]         o_status;
    logic               o_has_event;
    logic [1:0]         o_ready_mask;
    logic [DATA_W-1:0]  o_event_data;
    logic               o_last;

    t_request  request_q[$];
    t_response awaited_q[$];

    // Behavioural copy of the watch table.
    logic               watch_used [N_SLOTS];
    logic [FD_W-1:0]    watch_fd   [N_SLOTS];
    logic [INT_W-1:0]   watch_int  [N_SLOTS];
    logic [DATA_W-1:0]  watch_data [N_SLOTS];

    logic took = 1'b0;      // a transfer happened at the last rising edge
    int   gap_left  = 0;
    bit   gap_armed = 1'b0;
    int   err_cnt   = 0;
    int   stall_cnt = 0;
    int   xfer_cnt  = 0;
    int   poll_cnt  = 0;
    int   rsp_cnt   = 0;
    int   event_cnt = 0;
    int   status_seen [5] = '{default: 0};

    readiness_interest_table_core #(
        .TABLE_SLOTS(N_SLOTS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_fd              (i_fd),
        .i_interest        (i_interest),
        .i_user_data       (i_user_data),
        .i_max_events      (i_max_events),
        .i_open_mask       (i_open_mask),
        .i_read_ready_mask (i_read_ready_mask),
        .i_write_ready_mask(i_write_ready_mask),
        .o_result_strobe   (o_result_strobe),
        .o_status          (o_status),
        .o_has_event       (o_has_event),
        .o_ready_mask      (o_ready_mask),
        .o_event_data      (o_event_data),
        .o_last            (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Descriptors at or above FD_COUNT never count as open.
    function automatic logic fd_is_open(logic [FD_W-1:0] fd, logic [MASK_W-1:0] om);
        return ({1'b0, fd} < rit_pkg::FD_COUNT) && om[fd];
    endfunction

    // Apply one transferred request to the table copy and queue its responses.
    task automatic predict_table_response(input t_request rq);
        t_response rsp;
        t_response held;
        bit        have_held;
        bit        found;
        int        free_idx;
        int        cap;
        int        n;
        logic [1:0]      rdy;
        logic [FD_W-1:0] f;
        rsp       = '{status: rit_pkg::ST_OK, has_event: 1'b0, ready_mask: 2'b00,
                      event_data: '0, last: 1'b1};
        held      = rsp;
        have_held = 1'b0;
        found     = 1'b0;
        free_idx  = -1;
        n         = 0;
        if (rq.op != rit_pkg::OP_POLL) begin
            if (!fd_is_open(rq.fd, rq.open_mask)) begin
                rsp.status = rit_pkg::ST_NOT_OPEN;
            end else begin
                case (rq.op)
                    rit_pkg::OP_DEL: begin
                        // Clear every match; nothing to clear is still fine.
                        for (int i = 0; i < N_SLOTS; i++)
                            if (watch_used[i] && watch_fd[i] == rq.fd)
                                watch_used[i] = 1'b0;
                    end
                    rit_pkg::OP_MOD: begin
                        rsp.status = rit_pkg::ST_NOT_FOUND;
                        for (int i = 0; i < N_SLOTS; i++) begin
                            if (!found && watch_used[i] && watch_fd[i] == rq.fd) begin
                                watch_int[i]  = rq.interest;
                                watch_data[i] = rq.user_data;
                                found         = 1'b1;
                                rsp.status    = rit_pkg::ST_OK;
                            end
                        end
                    end
                    default: begin
                        // Add: a duplicate wins over a free slot; fill the lowest free.
                        for (int i = 0; i < N_SLOTS; i++) begin
                            if (watch_used[i] && watch_fd[i] == rq.fd)
                                found = 1'b1;
                            else if (!watch_used[i] && free_idx < 0)
                                free_idx = i;
                        end
                        if (found) begin
                            rsp.status = rit_pkg::ST_DUP;
                        end else if (free_idx < 0) begin
                            rsp.status = rit_pkg::ST_FULL;
                        end else begin
                            watch_used[free_idx] = 1'b1;
                            watch_fd[free_idx]   = rq.fd;
                            watch_int[free_idx]  = rq.interest;
                            watch_data[free_idx] = rq.user_data;
                        end
                    end
                endcase
            end
            awaited_q.push_back(rsp);
        end else begin
            cap = (rq.max_events > rit_pkg::RESULT_CAP) ? int'(rit_pkg::RESULT_CAP)
                                                        : int'(rq.max_events);
            // Hold each event back until the next is found, so the final one can
            // carry the last flag.
            for (int i = 0; i < N_SLOTS; i++) begin
                if (n < cap && watch_used[i]) begin
                    f = watch_fd[i];
                    if (fd_is_open(f, rq.open_mask)) begin
                        rdy = {watch_int[i][1] & rq.wr_mask[f],
                               watch_int[i][0] & rq.rd_mask[f]};
                        if (rdy != 2'b00) begin
                            if (have_held)
                                awaited_q.push_back(held);
                            held = '{status: rit_pkg::ST_OK, has_event: 1'b1,
                                     ready_mask: rdy, event_data: watch_data[i],
                                     last: 1'b0};
                            have_held = 1'b1;
                            n++;
                        end
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                awaited_q.push_back(held);
            end else begin
                awaited_q.push_back(rsp);
            end
        end
    endtask

    // Compare one strobed result with the oldest outstanding response.
    task automatic check_table_response();
        t_response want;
        if (awaited_q.size() == 0) begin
            $error("unexpected result: status %0d has_event %0d last %0d",
                   o_status, o_has_event, o_last);
            err_cnt++;
        end else begin
            want = awaited_q.pop_front();
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                err_cnt++;
            end
            if (o_has_event !== want.has_event) begin
                $error("has_event: expected %0d, got %0d", want.has_event, o_has_event);
                err_cnt++;
            end
            if (o_ready_mask !== want.ready_mask) begin
                $error("ready_mask: expected %0d, got %0d", want.ready_mask, o_ready_mask);
                err_cnt++;
            end
            if (o_event_data !== want.event_data) begin
                $error("event_data: expected %h, got %h", want.event_data, o_event_data);
                err_cnt++;
            end
            if (o_last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, o_last);
                err_cnt++;
            end
            if (want.status <= rit_pkg::ST_NOT_FOUND)
                status_seen[want.status]++;
            if (want.has_event)
                event_cnt++;
        end
        rsp_cnt++;
    endtask

    function automatic t_request mk_req(rit_pkg::t_op op, logic [FD_W-1:0] fd,
                                        logic [INT_W-1:0] interest, logic [DATA_W-1:0] data,
                                        logic [MAXEV_W-1:0] maxev, logic [MASK_W-1:0] om,
                                        logic [MASK_W-1:0] rd, logic [MASK_W-1:0] wr);
        t_request rq;
        rq.op         = op;
        rq.fd         = fd;
        rq.interest   = interest;
        rq.user_data  = data;
        rq.max_events = maxev;
        rq.open_mask  = om;
        rq.rd_mask    = rd;
        rq.wr_mask    = wr;
        rq.gap        = $urandom_range(0, 4);
        rq.drain      = 1'b0;
        return rq;
    endfunction

    // Mostly open descriptors so that control requests reach the table; now and
    // then an arbitrary mask to exercise refusal and poll skipping.
    function automatic logic [MASK_W-1:0] pick_open_mask();
        int r;
        logic [MASK_W-1:0] om;
        r  = $urandom_range(0, 9);
        om = '1;
        if (r >= 7)
            om = MASK_W'($urandom);
        else if (r >= 3)
            om[$urandom_range(0, MASK_W - 1)] = 1'b0;
        return om;
    endfunction

    function automatic t_request random_request(int idx);
        t_request rq;
        int r;
        rit_pkg::t_op op;
        logic [MAXEV_W-1:0] maxev;
        r = $urandom_range(0, 99);
        if (r < 35)
            op = rit_pkg::OP_ADD;
        else if (r < 55)
            op = rit_pkg::OP_DEL;
        else if (r < 75)
            op = rit_pkg::OP_MOD;
        else
            op = rit_pkg::OP_POLL;
        if ($urandom_range(0, 9) < 7)
            maxev = MAXEV_W'($urandom_range(1, 16));
        else
            maxev = MAXEV_W'($urandom_range(0, 31));
        rq = mk_req(op, FD_W'($urandom), INT_W'($urandom), {$urandom, $urandom}, maxev,
                    pick_open_mask(), MASK_W'($urandom), MASK_W'($urandom));
        // Run one stretch back to back, and pause for a full drain now and then.
        if (idx >= 150 && idx < 250)
            rq.gap = 0;
        rq.drain = (idx % 75 == 40);
        return rq;
    endfunction

    // Watchdog: give up once nothing has moved for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_result_strobe)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Monitor: check results first, then predict from whatever transfers now.
    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            if (o_result_strobe)
                check_table_response();
            took <= start && !busy;
            if (start && !busy) begin
                rq = mk_req(rit_pkg::t_op'(i_operation), i_fd, i_interest, i_user_data,
                            i_max_events, i_open_mask, i_read_ready_mask,
                            i_write_ready_mask);
                predict_table_response(rq);
                xfer_cnt++;
                if (rq.op == rit_pkg::OP_POLL)
                    poll_cnt++;
            end
        end
    end

    // Driver: hold a request until it transfers, then count down the next gap.
    always @(negedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (request_q.size() == 0) begin
                start <= 1'b0;
            end else begin
                if (!gap_armed) begin
                    gap_left  = request_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (request_q[0].drain && awaited_q.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    rq        = request_q.pop_front();
                    gap_armed = 1'b0;
                    i_operation        <= rq.op;
                    i_fd               <= rq.fd;
                    i_interest         <= rq.interest;
                    i_user_data        <= rq.user_data;
                    i_max_events       <= rq.max_events;
                    i_open_mask        <= rq.open_mask;
                    i_read_ready_mask  <= rq.rd_mask;
                    i_write_ready_mask <= rq.wr_mask;
                    start              <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_request rq;
        for (int i = 0; i < N_SLOTS; i++) begin
            watch_used[i] = 1'b0;
            watch_fd[i]   = '0;
            watch_int[i]  = '0;
            watch_data[i] = '0;
        end

        // Directed opening: empty poll, duplicate, refusal, missing entry.
        request_q.push_back(mk_req(rit_pkg::OP_POLL, 4'd0, 2'd0, '0, 5'd16, '1, '1, '1));
        request_q.push_back(mk_req(rit_pkg::OP_ADD, 4'd0, 2'd3, '1, 5'd0, '1, '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_ADD, 4'd0, 2'd1, '0, 5'd0, '1, '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_ADD, 4'd5, 2'd3, '1, 5'd1, 16'hFFDF,
                                   '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_MOD, 4'd7, 2'd2, '1, 5'd1, '1, '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_DEL, 4'd9, 2'd0, '0, 5'd1, '1, '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_ADD, 4'd15, 2'd1, '0, 5'd31, '1, '0, '0));
        request_q.push_back(mk_req(rit_pkg::OP_MOD, 4'd15, 2'd2, 64'hA5A5_5A5A_F00F_0FF0,
                                   5'd1, '1, '0, '0));
        // Fill the remaining slots. With as many slots as descriptors every
        // further add is a duplicate, so a full table cannot be reached.
        for (int f = 1; f < 15; f++)
            request_q.push_back(mk_req(rit_pkg::OP_ADD, FD_W'(f), INT_W'(f),
                                       {$urandom, $urandom}, 5'd16, '1, '0, '0));
        // Full table ready; saturated limit, zero limit, then a partial poll.
        request_q.push_back(mk_req(rit_pkg::OP_POLL, 4'd0, 2'd0, '0, 5'd31, '1, '1, '1));
        request_q.push_back(mk_req(rit_pkg::OP_POLL, 4'd0, 2'd0, '0, 5'd0, '1, '1, '1));
        rq = mk_req(rit_pkg::OP_POLL, 4'd0, 2'd0, '0, 5'd5, 16'hF0F0, 16'hAAAA, 16'h5555);
        rq.drain = 1'b1;
        request_q.push_back(rq);

        for (int k = 0; k < N_RANDOM; k++)
            request_q.push_back(random_request(k));

        // Synchronous reset, released on a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || start || awaited_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d transfers (%0d polls) and %0d results, %0d of them events.",
                 xfer_cnt, poll_cnt, rsp_cnt, event_cnt);
        $display("Status ok %0d, not open %0d, duplicate %0d, full %0d, not found %0d.",
                 status_seen[rit_pkg::ST_OK], status_seen[rit_pkg::ST_NOT_OPEN],
                 status_seen[rit_pkg::ST_DUP], status_seen[rit_pkg::ST_FULL],
                 status_seen[rit_pkg::ST_NOT_FOUND]);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
rtl/rit_pkg.sv
rtl/rit_ram.sv
rtl/rit_ctrl.sv
rtl/rit_dpath.sv
rtl/readiness_interest_table_core.sv
dv/readiness_interest_table_core_tb.sv
